### hdl/bra_pkg.sv
// Package for the resource allocator: field widths, register defaults,
// command, status and register index codes. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package bra_pkg;

	localparam int DEF_NUM_CUST    = 8;
	localparam int DEF_NUM_RES     = 4;
	localparam int DEF_COUNT_WIDTH = 8;

	localparam int FIELD_RES  = 4;
	localparam int AMT_W      = 8;
	localparam int MODE_W     = 3;
	localparam int CUST_W     = 3;
	localparam int STATUS_W   = 3;
	localparam int CUST_REG_W = 4;
	localparam int RES_REG_W  = 3;
	localparam int CFG_DATA_W = 4;
	localparam int CFG_IDX_W  = 1;

	localparam logic [CUST_REG_W-1:0] CUST_REG_RST = 4'd8;
	localparam logic [RES_REG_W-1:0]  RES_REG_RST  = 3'd4;

	typedef enum logic [MODE_W-1:0] {
		MODE_LOAD_MAX    = 3'd0,
		MODE_LOAD_AVAIL  = 3'd1,
		MODE_REQUEST     = 3'd2,
		MODE_RELEASE     = 3'd3,
		MODE_RELEASE_ALL = 3'd4
	} mode_t;

	typedef enum logic [STATUS_W-1:0] {
		STAT_DONE          = 3'd0,
		STAT_EXCEEDS_NEED  = 3'd1,
		STAT_INSUFFICIENT  = 3'd2,
		STAT_UNSAFE        = 3'd3,
		STAT_EXCEEDS_ALLOC = 3'd4
	} status_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_CUSTOMERS_IN_USE = 1'b0,
		CFG_RESOURCES_IN_USE = 1'b1
	} cfg_idx_t;

endpackage

`default_nettype wire

### hdl/bra_if.sv
// Valid/ready channels of the resource allocator: command and response.
// Depends on bra_pkg.
`timescale 1ns / 1ps
`default_nettype none

interface bra_cmd_if;
	logic                          valid;
	logic                          ready;
	logic [bra_pkg::MODE_W-1:0]    mode;
	logic [bra_pkg::CUST_W-1:0]    customer;
	logic [bra_pkg::AMT_W-1:0]     amount_r0;
	logic [bra_pkg::AMT_W-1:0]     amount_r1;
	logic [bra_pkg::AMT_W-1:0]     amount_r2;
	logic [bra_pkg::AMT_W-1:0]     amount_r3;

	modport source (output valid, mode, customer, amount_r0, amount_r1, amount_r2, amount_r3,
		input ready);
	modport sink (input valid, mode, customer, amount_r0, amount_r1, amount_r2, amount_r3,
		output ready);
endinterface

interface bra_rsp_if;
	logic                          valid;
	logic                          ready;
	logic [bra_pkg::STATUS_W-1:0]  status;
	logic                          safe;
	logic [bra_pkg::AMT_W-1:0]     avail_r0;
	logic [bra_pkg::AMT_W-1:0]     avail_r1;
	logic [bra_pkg::AMT_W-1:0]     avail_r2;
	logic [bra_pkg::AMT_W-1:0]     avail_r3;

	modport source (output valid, status, safe, avail_r0, avail_r1, avail_r2, avail_r3,
		input ready);
	modport sink (input valid, status, safe, avail_r0, avail_r1, avail_r2, avail_r3,
		output ready);
endinterface

`default_nettype wire

### hdl/bra_lane.sv
// One customer lane of the safety walk: checks the need row against work.
// No package dependency.
`timescale 1ns / 1ps
`default_nettype none

module bra_lane #(
	parameter int NUM_RES     = 4,
	parameter int COUNT_WIDTH = 8,
	parameter int WORK_W      = 12
) (
	input  wire logic [NUM_RES-1:0][COUNT_WIDTH-1:0] need_row,
	input  wire logic [NUM_RES-1:0][WORK_W-1:0]      work,
	input  wire logic [NUM_RES-1:0]                  res_en,
	input  wire logic                                active,
	input  wire logic                                done,
	output logic                                     fit
);

	always_comb begin
		fit = active && !done;
		for (int r = 0; r < NUM_RES; r++) begin
			if (res_en[r] && (WORK_W'(need_row[r]) > work[r])) begin
				fit = 1'b0;
			end
		end
	end

endmodule

`default_nettype wire

### hdl/bra_merge.sv
// Merge stage of the safety walk: adds the allocation rows of all fitting
// lanes into work through an adder tree. No package dependency.
`timescale 1ns / 1ps
`default_nettype none

module bra_merge #(
	parameter int NUM_CUST    = 8,
	parameter int NUM_RES     = 4,
	parameter int COUNT_WIDTH = 8,
	parameter int WORK_W      = 12
) (
	input  wire logic [NUM_CUST-1:0]                               fit,
	input  wire logic [NUM_CUST-1:0][NUM_RES-1:0][COUNT_WIDTH-1:0] alloc,
	input  wire logic [NUM_RES-1:0][WORK_W-1:0]                    work_in,
	output logic [NUM_RES-1:0][WORK_W-1:0]                         work_out,
	output logic                                                   progress
);

	localparam int LEAVES = 1 << $clog2(NUM_CUST);

	logic [WORK_W-1:0] node [NUM_RES][2*LEAVES];

	always_comb begin
		for (int r = 0; r < NUM_RES; r++) begin
			node[r][0] = '0;
			for (int i = 0; i < LEAVES; i++) begin
				node[r][LEAVES+i] = '0;
				if (i < NUM_CUST) begin
					if (fit[i]) begin
						node[r][LEAVES+i] = WORK_W'(alloc[i][r]);
					end
				end
			end
			for (int n = LEAVES - 1; n >= 1; n--) begin
				node[r][n] = node[r][2*n] + node[r][2*n+1];
			end
			work_out[r] = work_in[r] + node[r][1];
		end
	end

	assign progress = |fit;

endmodule

`default_nettype wire

### hdl/bankers_resource_allocator_unit.sv
// Top level of the deadlock-avoiding resource allocator: tables, command
// sequencer, safety-walk lanes. Depends on bra_pkg, bra_if, bra_lane, bra_merge.
//
// Usage: commands enter on cmd (valid/ready), one response per command
// leaves on rsp (valid/ready). cfg_we/cfg_index/cfg_data write the customer
// and resource counts; write them only while no command is in flight.
// Sequence: a load, release or refused request passes through ST_EXEC and
// ST_FINISH to the response register. An accepted request runs the safety
// walk: one lane per customer tests need against work, and fit_q registers
// the result; the merge then adds the allocations of all fitting customers
// into work. At most one pass per active customer plus one more run.
// One command is worked on at a time; cmd.ready is high only while idle,
// and a new command may enter while the last response waits on rsp.
// If rsp is stalled, a finished result holds in the sequencer until the
// response register is free.
// Reset clears all tables to zero, sets the registers to 8 customers and
// 4 resources, and drops any pending response.
`timescale 1ns / 1ps
`default_nettype none

module bankers_resource_allocator_unit #(
	parameter int NUM_CUST    = bra_pkg::DEF_NUM_CUST,
	parameter int NUM_RES     = bra_pkg::DEF_NUM_RES,
	parameter int COUNT_WIDTH = bra_pkg::DEF_COUNT_WIDTH
) (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire logic                           cfg_we,
	input  wire logic [bra_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [bra_pkg::CFG_DATA_W-1:0] cfg_data,
	bra_cmd_if.sink                             cmd,
	bra_rsp_if.source                           rsp
);

	localparam int AW     = (COUNT_WIDTH > bra_pkg::AMT_W) ? COUNT_WIDTH : bra_pkg::AMT_W;
	localparam int WORK_W = COUNT_WIDTH + $clog2(NUM_CUST + 1);
	localparam logic [COUNT_WIDTH-1:0] COUNT_MAX = '1;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_EXEC,
		ST_WALK_INIT,
		ST_WALK_FIT,
		ST_WALK_MERGE,
		ST_FINISH
	} state_t;

	function automatic logic [COUNT_WIDTH-1:0] sat_add(input logic [COUNT_WIDTH-1:0] a,
		input logic [AW-1:0] b);
		logic [AW:0] s;
		s = (AW+1)'(a) + (AW+1)'(b);
		return (s > (AW+1)'(COUNT_MAX)) ? COUNT_MAX : s[COUNT_WIDTH-1:0];
	endfunction

	state_t                                 state_q;
	logic [bra_pkg::CUST_REG_W-1:0]         cust_reg_q;
	logic [bra_pkg::RES_REG_W-1:0]          res_reg_q;
	logic [NUM_RES-1:0][COUNT_WIDTH-1:0]    avail_q;
	logic [NUM_CUST-1:0][NUM_RES-1:0][COUNT_WIDTH-1:0] alloc_q;
	logic [NUM_CUST-1:0][NUM_RES-1:0][COUNT_WIDTH-1:0] need_q;
	logic [NUM_RES-1:0][WORK_W-1:0]         work_q;
	logic [NUM_CUST-1:0]                    done_q;
	logic [NUM_CUST-1:0]                    fit_q;
	bra_pkg::status_t                       status_q;
	logic                                   safe_q;
	logic                                   rsp_valid_q;
	logic [bra_pkg::STATUS_W-1:0]           rsp_status_q;
	logic                                   rsp_safe_q;
	logic [bra_pkg::AMT_W-1:0]              rsp_avail_q [bra_pkg::FIELD_RES];

	logic [bra_pkg::MODE_W-1:0]             mode_q;
	logic [bra_pkg::CUST_W-1:0]             cust_q;
	logic [bra_pkg::AMT_W-1:0]              amt_q [NUM_RES];

	logic [bra_pkg::AMT_W-1:0]              amt_all [bra_pkg::FIELD_RES];
	logic [bra_pkg::AMT_W-1:0]              avail_out [bra_pkg::FIELD_RES];
	logic [NUM_CUST-1:0]                    sel;
	logic                                   cust_ok;
	logic [NUM_CUST-1:0]                    active;
	logic [NUM_RES-1:0]                     res_en;
	logic [NUM_RES-1:0][COUNT_WIDTH-1:0]    row_alloc;
	logic [NUM_RES-1:0][COUNT_WIDTH-1:0]    row_need;
	logic [AW-1:0]                          amt_ext [NUM_RES];
	logic [COUNT_WIDTH-1:0]                 amt_cw [NUM_RES];
	logic [COUNT_WIDTH-1:0]                 ld_val [NUM_RES];
	logic [NUM_RES-1:0]                     over_need;
	logic [NUM_RES-1:0]                     over_avail;
	logic [NUM_RES-1:0]                     over_alloc;
	logic [NUM_CUST-1:0]                    fit;
	logic [NUM_RES-1:0][WORK_W-1:0]         work_sum;
	logic                                   progress;
	logic                                   accept;
	logic                                   load_rsp;

	assign amt_all[0] = cmd.amount_r0;
	assign amt_all[1] = cmd.amount_r1;
	assign amt_all[2] = cmd.amount_r2;
	assign amt_all[3] = cmd.amount_r3;

	assign cmd.ready = (state_q == ST_IDLE);
	assign accept    = cmd.valid && cmd.ready;
	assign load_rsp  = (state_q == ST_FINISH) && (!rsp_valid_q || rsp.ready);

	always_comb begin
		for (int i = 0; i < NUM_CUST; i++) begin
			sel[i]    = ({29'd0, cust_q} == 32'(i));
			active[i] = (cust_reg_q == '0) ? (i == 0) : (i < int'(cust_reg_q));
		end
		for (int r = 0; r < NUM_RES; r++) begin
			res_en[r] = (res_reg_q == '0) ? (r == 0) : (r < int'(res_reg_q));
		end
	end

	assign cust_ok = |sel;

	always_comb begin
		row_alloc = '0;
		row_need  = '0;
		for (int i = 0; i < NUM_CUST; i++) begin
			if (sel[i]) begin
				row_alloc = row_alloc | alloc_q[i];
				row_need  = row_need | need_q[i];
			end
		end
	end

	always_comb begin
		for (int r = 0; r < NUM_RES; r++) begin
			amt_ext[r]    = AW'(amt_q[r]);
			amt_cw[r]     = amt_ext[r][COUNT_WIDTH-1:0];
			ld_val[r]     = (amt_ext[r] > AW'(COUNT_MAX)) ? COUNT_MAX : amt_cw[r];
			over_need[r]  = res_en[r] && (amt_ext[r] > AW'(row_need[r]));
			over_avail[r] = res_en[r] && (amt_ext[r] > AW'(avail_q[r]));
			over_alloc[r] = res_en[r] && (amt_ext[r] > AW'(row_alloc[r]));
		end
	end

	for (genvar k = 0; k < bra_pkg::FIELD_RES; k++) begin : g_avail
		if (k < NUM_RES) begin : g_used
			logic [AW-1:0] ext;
			assign ext          = AW'(avail_q[k]);
			assign avail_out[k] = ext[bra_pkg::AMT_W-1:0];
		end else begin : g_unused
			assign avail_out[k] = '0;
		end
	end

	for (genvar i = 0; i < NUM_CUST; i++) begin : g_lane
		bra_lane #(
			.NUM_RES     (NUM_RES),
			.COUNT_WIDTH (COUNT_WIDTH),
			.WORK_W      (WORK_W)
		) u_lane (
			.need_row (need_q[i]),
			.work     (work_q),
			.res_en   (res_en),
			.active   (active[i]),
			.done     (done_q[i]),
			.fit      (fit[i])
		);
	end

	bra_merge #(
		.NUM_CUST    (NUM_CUST),
		.NUM_RES     (NUM_RES),
		.COUNT_WIDTH (COUNT_WIDTH),
		.WORK_W      (WORK_W)
	) u_merge (
		.fit      (fit_q),
		.alloc    (alloc_q),
		.work_in  (work_q),
		.work_out (work_sum),
		.progress (progress)
	);

	always_ff @(posedge clk) begin
		if (accept) begin
			mode_q <= cmd.mode;
			cust_q <= cmd.customer;
			for (int r = 0; r < NUM_RES; r++) begin
				amt_q[r] <= amt_all[r];
			end
		end
		if (load_rsp) begin
			rsp_status_q <= status_q;
			rsp_safe_q   <= safe_q;
			rsp_avail_q  <= avail_out;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			cust_reg_q  <= bra_pkg::CUST_REG_RST;
			res_reg_q   <= bra_pkg::RES_REG_RST;
			avail_q     <= '0;
			alloc_q     <= '0;
			need_q      <= '0;
			work_q      <= '0;
			done_q      <= '0;
			fit_q       <= '0;
			status_q    <= bra_pkg::STAT_DONE;
			safe_q      <= 1'b0;
			rsp_valid_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					bra_pkg::CFG_CUSTOMERS_IN_USE: cust_reg_q <= cfg_data[bra_pkg::CUST_REG_W-1:0];
					bra_pkg::CFG_RESOURCES_IN_USE: res_reg_q  <= cfg_data[bra_pkg::RES_REG_W-1:0];
					default: ;
				endcase
			end
			if (rsp.ready) begin
				rsp_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						state_q <= ST_EXEC;
					end
				end
				ST_EXEC: begin
					status_q <= bra_pkg::STAT_DONE;
					safe_q   <= 1'b0;
					state_q  <= ST_FINISH;
					if (cust_ok) begin
						case (mode_q)
							bra_pkg::MODE_LOAD_MAX: begin
								for (int i = 0; i < NUM_CUST; i++) begin
									for (int r = 0; r < NUM_RES; r++) begin
										if (sel[i] && res_en[r]) begin
											alloc_q[i][r] <= '0;
											need_q[i][r]  <= ld_val[r];
										end
									end
								end
							end
							bra_pkg::MODE_LOAD_AVAIL: begin
								for (int r = 0; r < NUM_RES; r++) begin
									if (res_en[r]) begin
										avail_q[r] <= ld_val[r];
									end
								end
							end
							bra_pkg::MODE_REQUEST: begin
								if (|over_need) begin
									status_q <= bra_pkg::STAT_EXCEEDS_NEED;
								end else if (|over_avail) begin
									status_q <= bra_pkg::STAT_INSUFFICIENT;
								end else begin
									for (int r = 0; r < NUM_RES; r++) begin
										if (res_en[r]) begin
											avail_q[r] <= avail_q[r] - amt_cw[r];
										end
									end
									for (int i = 0; i < NUM_CUST; i++) begin
										for (int r = 0; r < NUM_RES; r++) begin
											if (sel[i] && res_en[r]) begin
												alloc_q[i][r] <= sat_add(row_alloc[r], amt_ext[r]);
												need_q[i][r]  <= row_need[r] - amt_cw[r];
											end
										end
									end
									state_q <= ST_WALK_INIT;
								end
							end
							bra_pkg::MODE_RELEASE: begin
								if (|over_alloc) begin
									status_q <= bra_pkg::STAT_EXCEEDS_ALLOC;
								end else begin
									for (int r = 0; r < NUM_RES; r++) begin
										if (res_en[r]) begin
											avail_q[r] <= sat_add(avail_q[r], amt_ext[r]);
										end
									end
									for (int i = 0; i < NUM_CUST; i++) begin
										for (int r = 0; r < NUM_RES; r++) begin
											if (sel[i] && res_en[r]) begin
												alloc_q[i][r] <= row_alloc[r] - amt_cw[r];
												need_q[i][r]  <= sat_add(row_need[r], amt_ext[r]);
											end
										end
									end
								end
							end
							bra_pkg::MODE_RELEASE_ALL: begin
								for (int r = 0; r < NUM_RES; r++) begin
									if (res_en[r]) begin
										avail_q[r] <= sat_add(avail_q[r], AW'(row_alloc[r]));
									end
								end
								for (int i = 0; i < NUM_CUST; i++) begin
									for (int r = 0; r < NUM_RES; r++) begin
										if (sel[i] && res_en[r]) begin
											alloc_q[i][r] <= '0;
											need_q[i][r]  <= sat_add(row_need[r], AW'(row_alloc[r]));
										end
									end
								end
							end
							default: ;
						endcase
					end
				end
				ST_WALK_INIT: begin
					for (int r = 0; r < NUM_RES; r++) begin
						work_q[r] <= res_en[r] ? WORK_W'(avail_q[r]) : '0;
					end
					done_q  <= '0;
					state_q <= ST_WALK_FIT;
				end
				ST_WALK_FIT: begin
					fit_q   <= fit;
					state_q <= ST_WALK_MERGE;
				end
				ST_WALK_MERGE: begin
					if (progress) begin
						work_q  <= work_sum;
						done_q  <= done_q | fit_q;
						state_q <= ST_WALK_FIT;
					end else begin
						if ((done_q & active) == active) begin
							safe_q <= 1'b1;
						end else begin
							status_q <= bra_pkg::STAT_UNSAFE;
							for (int r = 0; r < NUM_RES; r++) begin
								if (res_en[r]) begin
									avail_q[r] <= avail_q[r] + amt_cw[r];
								end
							end
							for (int i = 0; i < NUM_CUST; i++) begin
								for (int r = 0; r < NUM_RES; r++) begin
									if (sel[i] && res_en[r]) begin
										alloc_q[i][r] <= row_alloc[r] - amt_cw[r];
										need_q[i][r]  <= row_need[r] + amt_cw[r];
									end
								end
							end
						end
						state_q <= ST_FINISH;
					end
				end
				ST_FINISH: begin
					if (load_rsp) begin
						rsp_valid_q <= 1'b1;
						state_q     <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign rsp.valid    = rsp_valid_q;
	assign rsp.status   = rsp_status_q;
	assign rsp.safe     = rsp_safe_q;
	assign rsp.avail_r0 = rsp_avail_q[0];
	assign rsp.avail_r1 = rsp_avail_q[1];
	assign rsp.avail_r2 = rsp_avail_q[2];
	assign rsp.avail_r3 = rsp_avail_q[3];

endmodule

`default_nettype wire
